// File: sv/pfp_pkg.sv
// Shared types and constants for the particle frame parser.
`default_nettype none

package pfp_pkg;

  localparam logic [7:0]  START_BYTE_A  = 8'h42;
  localparam logic [7:0]  START_BYTE_B  = 8'h4D;
  localparam logic [15:0] LENGTH_EXPECT = 16'd28;
  localparam logic [15:0] SUM_SEED      = 16'h008F;  // 0x42 + 0x4D

  // Frame byte positions while collecting.
  localparam logic [4:0] POS_FIRST    = 5'd2;
  localparam logic [4:0] POS_LEN_HI   = 5'd2;
  localparam logic [4:0] POS_LEN_LO   = 5'd3;
  localparam logic [4:0] POS_VAL_HI   = 5'd12;
  localparam logic [4:0] POS_VAL_LO   = 5'd13;
  localparam logic [4:0] POS_SUM_END  = 5'd30;
  localparam logic [4:0] POS_LAST     = 5'd31;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_START = 2'd1;
  localparam logic [1:0] ST_BAD_LEN   = 2'd2;
  localparam logic [1:0] ST_BAD_SUM   = 2'd3;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_SECOND  = 3'b010,
    PH_COLLECT = 3'b100
  } phase_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  status;
    logic [15:0] value;
  } result_t;

endpackage

`default_nettype wire

// File: sv/pfp_parser.sv
// Frame parser state and the per-word decision logic.
`default_nettype none

module pfp_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [7:0]  rx_byte,
  output pfp_pkg::result_t res
);

  pfp_pkg::phase_t phase, phase_next;
  logic [4:0]  byte_position, byte_position_next;
  logic [15:0] running_sum, running_sum_next;
  logic [15:0] length_word, length_word_next;
  logic [15:0] captured_value, captured_value_next;
  logic [7:0]  checksum_high, checksum_high_next;
  logic [15:0] trailer;

  assign trailer = {checksum_high, rx_byte};

  always_comb begin
    phase_next          = phase;
    byte_position_next  = byte_position;
    running_sum_next    = running_sum;
    length_word_next    = length_word;
    captured_value_next = captured_value;
    checksum_high_next  = checksum_high;
    res                 = '0;
    case (phase)
      pfp_pkg::PH_SECOND: begin
        if (rx_byte != pfp_pkg::START_BYTE_B) begin
          // The failing word is not rechecked as a start word.
          phase_next = pfp_pkg::PH_HUNT;
          res.valid  = 1'b1;
          res.status = pfp_pkg::ST_BAD_START;
        end else begin
          phase_next         = pfp_pkg::PH_COLLECT;
          byte_position_next = pfp_pkg::POS_FIRST;
          running_sum_next   = pfp_pkg::SUM_SEED;
        end
      end
      pfp_pkg::PH_COLLECT: begin
        if (byte_position < pfp_pkg::POS_SUM_END) begin
          running_sum_next = running_sum + {8'd0, rx_byte};
        end
        case (byte_position)
          pfp_pkg::POS_LEN_HI:  length_word_next    = {rx_byte, 8'd0};
          pfp_pkg::POS_LEN_LO:  length_word_next    = {length_word[15:8], rx_byte};
          pfp_pkg::POS_VAL_HI:  captured_value_next = {rx_byte, 8'd0};
          pfp_pkg::POS_VAL_LO:  captured_value_next = {captured_value[15:8], rx_byte};
          pfp_pkg::POS_SUM_END: checksum_high_next  = rx_byte;
          default: ;
        endcase
        if (byte_position == pfp_pkg::POS_LAST) begin
          phase_next         = pfp_pkg::PH_HUNT;
          byte_position_next = '0;
          res.valid          = 1'b1;
          if (length_word != pfp_pkg::LENGTH_EXPECT) begin
            res.status = pfp_pkg::ST_BAD_LEN;
          end else if (trailer != running_sum) begin
            res.status = pfp_pkg::ST_BAD_SUM;
          end else begin
            res.status = pfp_pkg::ST_OK;
            res.value  = captured_value;
          end
        end else begin
          byte_position_next = byte_position + 5'd1;
        end
      end
      default: begin
        if (rx_byte == pfp_pkg::START_BYTE_A) begin
          phase_next = pfp_pkg::PH_SECOND;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= pfp_pkg::PH_HUNT;
      byte_position  <= '0;
      running_sum    <= '0;
      length_word    <= '0;
      captured_value <= '0;
      checksum_high  <= '0;
    end else if (step) begin
      phase          <= phase_next;
      byte_position  <= byte_position_next;
      running_sum    <= running_sum_next;
      length_word    <= length_word_next;
      captured_value <= captured_value_next;
      checksum_high  <= checksum_high_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/particle_frame_parser_core.sv
// A word waits in the input register until the output register is free or being
// emptied; a frame-ending word or a failed start check writes its result there.
// Throughput: one word per cycle while out_ready is high; a result that waits on
// out_ready stalls the input once the input register also holds a word.
// Reset: synchronous, active high; the parser returns to hunting for a start
// word and both the input and output registers are emptied.
`default_nettype none

module particle_frame_parser_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       frame_status,
  output logic [15:0]      particle_value
);

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             advance;
  pfp_pkg::result_t res;

  // A held word moves on once the output register has room for its result.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  pfp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (s1_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      frame_status   <= res.status;
      particle_value <= res.value;
    end
  end

`ifndef SYNTHESIS
  a_value_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (frame_status != pfp_pkg::ST_OK) |-> particle_value == 16'd0)
    else $error("particle value nonzero on a failed frame");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while held word cannot advance");

  a_reset_empties: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !s1_valid)
    else $error("registers not empty after reset");
`endif

endmodule

`default_nettype wire
